// ===== rtl/core/ldc_pkg.sv =====
package ldc_pkg;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_RX_DONE,
    OP_TX_PEND,
    OP_TX_END,
    OP_SEND,
    OP_NONE
  } op_t;

  localparam int OpBits = 3;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_START    = 3'd1;
  localparam logic [2:0] REQ_RX_DONE  = 3'd2;
  localparam logic [2:0] REQ_TX_PEND  = 3'd3;
  localparam logic [2:0] REQ_TX_DONE  = 3'd4;
  localparam logic [2:0] REQ_TX_FAIL  = 3'd5;
  localparam logic [2:0] REQ_SEND     = 3'd6;

  localparam logic [1:0] CFG_DUTY_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_SLEEP_TICKS  = 2'd1;
  localparam logic [1:0] CFG_LISTEN_TICKS = 2'd2;
  localparam logic [1:0] CFG_GUARD_TICKS  = 2'd3;

  localparam logic [1:0] RADIO_KEEP   = 2'd0;
  localparam logic [1:0] RADIO_SLEEP  = 2'd1;
  localparam logic [1:0] RADIO_LISTEN = 2'd2;

  localparam logic [1:0] TX_NONE    = 2'd0;
  localparam logic [1:0] TX_DATA    = 2'd1;
  localparam logic [1:0] TX_DATA_REQ = 2'd2;

  localparam logic [31:0] RESET_SLEEP_TICKS  = 32'd1000000;
  localparam logic [31:0] RESET_LISTEN_TICKS = 32'd100000;
  localparam logic [31:0] RESET_GUARD_TICKS  = 32'd50000;

  typedef struct packed {
    logic        duty_enable;
    logic [31:0] sleep_ticks;
    logic [31:0] listen_ticks;
    logic [31:0] guard_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/ldc_front.sv =====
module ldc_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic              queue_ready,
  output logic              push,
  output ldc_pkg::op_t      op
);
  import ldc_pkg::*;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  always_comb begin
    case (req_type)
      REQ_TICK:    op = OP_TICK;
      REQ_START:   op = OP_START;
      REQ_RX_DONE: op = OP_RX_DONE;
      REQ_TX_PEND: op = OP_TX_PEND;
      REQ_TX_DONE,
      REQ_TX_FAIL: op = OP_TX_END;
      REQ_SEND:    op = OP_SEND;
      default:     op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/ldc_fifo.sv =====
module ldc_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [Width-1:0] pop_data
);

  logic [Width-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ldc_back.sv =====
module ldc_back #(
  parameter int QUEUE_DEPTH = 4,
  parameter int HANDLE_BITS = 8,
  parameter int TIMER_BITS  = 32,
  localparam int CountBits  = $clog2(QUEUE_DEPTH + 1),
  localparam int IdxBits    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ldc_pkg::cfg_t          cfg,
  input  logic                   take_valid,
  output logic                   take,
  input  ldc_pkg::op_t           take_op,
  input  logic [HANDLE_BITS-1:0] take_handle,
  input  logic [31:0]            take_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             radio_mode,
  output logic [1:0]             transmit_kind,
  output logic [HANDLE_BITS-1:0] tx_handle,
  output logic                   release_valid,
  output logic [HANDLE_BITS-1:0] released_handle,
  output logic                   forward_rx,
  output logic                   dropped,
  output logic [2:0]             mac_state,
  output logic [CountBits-1:0]   queued_count
);
  import ldc_pkg::*;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_SLEEP  = 3'd1,
    MODE_TXREQ  = 3'd2,
    MODE_TXDATA = 3'd3,
    MODE_DBR    = 3'd4,
    MODE_LISTEN = 3'd5
  } mode_t;

  mode_t                  mode, mode_next;
  logic [TIMER_BITS-1:0]  countdown, countdown_next;
  logic                   armed, armed_next;
  logic                   busy, busy_next;
  logic [CountBits-1:0]   pending, pending_next;
  logic [HANDLE_BITS-1:0] queue [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] queue_next [QUEUE_DEPTH];

  logic [1:0]             rmode;
  logic [1:0]             tkind;
  logic [HANDLE_BITS-1:0] thandle;
  logic                   relv;
  logic [HANDLE_BITS-1:0] relh;
  logic                   fwd;
  logic                   drop;
  logic                   run_ev;
  logic                   remove;

  assign take = take_valid && (!out_valid || out_ready);

  always_comb begin
    mode_next      = mode;
    countdown_next = countdown;
    armed_next     = armed;
    busy_next      = busy;
    pending_next   = pending;
    queue_next     = queue;
    rmode          = RADIO_KEEP;
    tkind          = TX_NONE;
    thandle        = '0;
    relv           = 1'b0;
    relh           = '0;
    fwd            = 1'b0;
    drop           = 1'b0;
    run_ev         = 1'b0;
    remove         = 1'b0;

    case (take_op)
      OP_TICK: begin
        if (armed) begin
          if (countdown <= TIMER_BITS'(1)) begin
            countdown_next = '0;
            armed_next     = 1'b0;
            case (mode)
              MODE_SLEEP: begin
                mode_next = (pending != '0) ? MODE_DBR : MODE_TXREQ;
                run_ev    = 1'b1;
              end
              MODE_LISTEN: begin
                mode_next = MODE_SLEEP;
                run_ev    = 1'b1;
              end
              MODE_TXDATA: mode_next = MODE_DBR;
              default: ;
            endcase
          end else begin
            countdown_next = countdown - TIMER_BITS'(1);
          end
        end
      end
      OP_START: begin
        if (mode == MODE_INIT) begin
          if (cfg.duty_enable) begin
            mode_next      = MODE_LISTEN;
            rmode          = RADIO_LISTEN;
            countdown_next = take_offset[TIMER_BITS-1:0];
            armed_next     = 1'b1;
          end else begin
            rmode = RADIO_SLEEP;
          end
        end
      end
      OP_RX_DONE: begin
        fwd = 1'b1;
        if (cfg.duty_enable) begin
          armed_next = 1'b0;
          mode_next  = MODE_SLEEP;
          run_ev     = 1'b1;
        end
      end
      OP_TX_PEND: begin
        if (mode != MODE_INIT) begin
          busy_next  = 1'b0;
          armed_next = 1'b0;
          mode_next  = MODE_LISTEN;
          run_ev     = 1'b1;
        end
      end
      OP_TX_END: begin
        if (mode != MODE_INIT) begin
          busy_next = 1'b0;
          if (mode == MODE_TXREQ) begin
            armed_next = 1'b0;
            mode_next  = MODE_SLEEP;
            run_ev     = 1'b1;
          end else if (mode == MODE_TXDATA && pending == '0) begin
            run_ev = 1'b1;
          end else if (pending != '0) begin
            armed_next = 1'b0;
            remove     = 1'b1;
          end
        end
      end
      OP_SEND: begin
        if (mode == MODE_INIT) begin
          tkind   = TX_DATA;
          thandle = take_handle;
        end else if ((armed && (32'(countdown) < cfg.guard_ticks)) ||
                     pending != '0 || busy) begin
          if (pending < CountBits'(QUEUE_DEPTH)) begin
            queue_next[pending[IdxBits-1:0]] = take_handle;
            pending_next = pending + CountBits'(1);
          end else begin
            drop = 1'b1;
          end
        end else begin
          mode_next = MODE_TXDATA;
          busy_next = 1'b1;
          tkind     = TX_DATA;
          thandle   = take_handle;
        end
      end
      default: ;
    endcase

    // release the head, then send the next one or close the exchange
    if (remove) begin
      relv         = 1'b1;
      relh         = queue[0];
      pending_next = pending - CountBits'(1);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        queue_next[i] = queue[i+1];
      end
      if (pending_next != '0) begin
        tkind     = TX_DATA;
        thandle   = queue_next[0];
        busy_next = 1'b1;
      end else if (mode == MODE_DBR) begin
        mode_next = MODE_TXREQ;
        tkind     = TX_DATA_REQ;
      end else begin
        mode_next      = MODE_SLEEP;
        rmode          = RADIO_SLEEP;
        countdown_next = cfg.sleep_ticks[TIMER_BITS-1:0];
        armed_next     = 1'b1;
      end
    end

    // self-posted duty-cycle event in the new state
    if (run_ev && cfg.duty_enable) begin
      case (mode_next)
        MODE_TXREQ: tkind = TX_DATA_REQ;
        MODE_TXDATA: begin
          mode_next = MODE_SLEEP;
          rmode     = RADIO_SLEEP;
        end
        MODE_DBR: begin
          tkind     = TX_DATA;
          thandle   = queue[0];
          busy_next = 1'b1;
        end
        MODE_LISTEN: begin
          rmode          = RADIO_LISTEN;
          countdown_next = cfg.listen_ticks[TIMER_BITS-1:0];
          armed_next     = 1'b1;
        end
        MODE_SLEEP: begin
          rmode          = RADIO_SLEEP;
          countdown_next = cfg.sleep_ticks[TIMER_BITS-1:0];
          armed_next     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_INIT;
      countdown <= '0;
      armed     <= 1'b0;
      busy      <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mode      <= mode_next;
        countdown <= countdown_next;
        armed     <= armed_next;
        busy      <= busy_next;
        pending   <= pending_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      queue           <= queue_next;
      radio_mode      <= rmode;
      transmit_kind   <= tkind;
      tx_handle       <= thandle;
      release_valid   <= relv;
      released_handle <= relh;
      forward_rx      <= fwd;
      dropped         <= drop;
      mac_state       <= 3'(mode_next);
      queued_count    <= pending_next;
    end
  end

endmodule

// ===== rtl/core/leaf_duty_cycle_mac_controller.sv =====
// Leaf-node radio duty-cycle controller.
// Input channel (in_valid/in_ready) carries one event item: req_type,
// packet_handle for send requests and start_offset for start. Every item
// gives exactly one result item on the output channel (out_valid/out_ready):
// radio command, transmit command, released queue head, forward and drop
// flags, plus the mode and queue fill after the event.
// A front stage decodes each item into a two-entry queue; the back stage
// executes one event per cycle against the mode, wake-up countdown and the
// packet FIFO and loads the output register.
// An accepted item is written into the two-entry queue, and its result into the output register.
// Throughput: one item per cycle while the receiver takes results.
// When the receiver stalls the output register holds, the back stage stops,
// and the input keeps accepting until the two-entry queue is full.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect once registered;
// the user must make them while no item is in flight; the block does not enforce this.
// Reset (rst, synchronous) returns the registers to their defaults, the
// mode to init, the timer disarmed and the packet queue empty.
module leaf_duty_cycle_mac_controller #(
  parameter int QUEUE_DEPTH = 4,
  parameter int HANDLE_BITS = 8,
  parameter int TIMER_BITS  = 32,
  localparam int CountBits  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             req_type,
  input  logic [HANDLE_BITS-1:0] packet_handle,
  input  logic [31:0]            start_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             radio_mode,
  output logic [1:0]             transmit_kind,
  output logic [HANDLE_BITS-1:0] tx_handle,
  output logic                   release_valid,
  output logic [HANDLE_BITS-1:0] released_handle,
  output logic                   forward_rx,
  output logic                   dropped,
  output logic [2:0]             mac_state,
  output logic [CountBits-1:0]   queued_count
);
  import ldc_pkg::*;

  localparam int EntryBits = OpBits + HANDLE_BITS + 32;

  cfg_t                   cfg;
  op_t                    front_op;
  logic                   push;
  logic                   queue_ready;
  logic [EntryBits-1:0]   push_data;
  logic [EntryBits-1:0]   pop_data;
  logic                   pop_valid;
  logic                   take;
  op_t                    take_op;
  logic [HANDLE_BITS-1:0] take_handle;
  logic [31:0]            take_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_enable  <= 1'b1;
      cfg.sleep_ticks  <= RESET_SLEEP_TICKS;
      cfg.listen_ticks <= RESET_LISTEN_TICKS;
      cfg.guard_ticks  <= RESET_GUARD_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DUTY_ENABLE:  cfg.duty_enable  <= cfg_data[0];
        CFG_SLEEP_TICKS:  cfg.sleep_ticks  <= cfg_data;
        CFG_LISTEN_TICKS: cfg.listen_ticks <= cfg_data;
        CFG_GUARD_TICKS:  cfg.guard_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  ldc_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .queue_ready (queue_ready),
    .push        (push),
    .op          (front_op)
  );

  assign push_data = {front_op, packet_handle, start_offset};

  ldc_fifo #(
    .Width (EntryBits)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (queue_ready),
    .pop        (take),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  assign take_op     = op_t'(pop_data[EntryBits-1 -: OpBits]);
  assign take_handle = pop_data[32 +: HANDLE_BITS];
  assign take_offset = pop_data[31:0];

  ldc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .take_valid      (pop_valid),
    .take            (take),
    .take_op         (take_op),
    .take_handle     (take_handle),
    .take_offset     (take_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .radio_mode      (radio_mode),
    .transmit_kind   (transmit_kind),
    .tx_handle       (tx_handle),
    .release_valid   (release_valid),
    .released_handle (released_handle),
    .forward_rx      (forward_rx),
    .dropped         (dropped),
    .mac_state       (mac_state),
    .queued_count    (queued_count)
  );

endmodule

// ===== test/leaf_duty_cycle_mac_controller_test.sv =====
module leaf_duty_cycle_mac_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ldc_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    MODE_INIT,
    MODE_SLEEP,
    MODE_TX_REQ,
    MODE_TX_DATA,
    MODE_DATA_FIRST,
    MODE_LISTEN
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [31:0] offset;
  } mac_event_t;

  typedef struct packed {
    logic [1:0] radio;
    logic [1:0] tkind;
    logic [7:0] thandle;
    logic       relv;
    logic [7:0] relh;
    logic       fwd;
    logic       drop;
    logic [2:0] state;
    logic [2:0] count;
  } mac_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_DUTY_ENABLE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = REQ_TICK;
  logic [7:0]  packet_handle = '0;
  logic [31:0] start_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  radio_mode;
  logic [1:0]  transmit_kind;
  logic [7:0]  tx_handle;
  logic        release_valid;
  logic [7:0]  released_handle;
  logic        forward_rx;
  logic        dropped;
  logic [2:0]  mac_state;
  logic [2:0]  queued_count;

  leaf_duty_cycle_mac_controller dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .packet_handle(packet_handle),
    .start_offset(start_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .radio_mode(radio_mode),
    .transmit_kind(transmit_kind),
    .tx_handle(tx_handle),
    .release_valid(release_valid),
    .released_handle(released_handle),
    .forward_rx(forward_rx),
    .dropped(dropped),
    .mac_state(mac_state),
    .queued_count(queued_count)
  );

  // predicted controller state and registers
  logic        duty_en = 1'b1;
  logic [31:0] sleep_len = RESET_SLEEP_TICKS;
  logic [31:0] listen_len = RESET_LISTEN_TICKS;
  logic [31:0] guard_len = RESET_GUARD_TICKS;
  mode_t       mode = MODE_INIT;
  logic [31:0] countdown = '0;
  logic        armed = 1'b0;
  logic        busy = 1'b0;
  int          fill = 0;
  logic [7:0]  fifo [QDEPTH];
  mac_result_t res;

  mac_event_t  event_queue[$];
  mac_result_t expected_results[$];
  mac_event_t  drive_ev;
  mac_result_t want;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;

  function automatic void arm_timer(input logic [31:0] v);
    countdown = v;
    armed = 1'b1;
  endfunction

  function automatic void send_head();
    res.tkind = TX_DATA;
    res.thandle = fifo[0];
    busy = 1'b1;
  endfunction

  // self-posted duty-cycle event, acts on the current mode
  function automatic void duty_event();
    if (duty_en) begin
      case (mode)
        MODE_TX_REQ: res.tkind = TX_DATA_REQ;
        MODE_TX_DATA: begin
          mode = MODE_SLEEP;
          res.radio = RADIO_SLEEP;
        end
        MODE_DATA_FIRST: send_head();
        MODE_LISTEN: begin
          res.radio = RADIO_LISTEN;
          arm_timer(listen_len);
        end
        MODE_SLEEP: begin
          res.radio = RADIO_SLEEP;
          arm_timer(sleep_len);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic mac_result_t predict_event(input mac_event_t ev);
    int i;
    res = '0;
    case (ev.kind)
      REQ_TICK: begin
        if (armed) begin
          if (countdown <= 32'd1) begin
            countdown = '0;
            armed = 1'b0;
            case (mode)
              MODE_SLEEP: begin
                mode = (fill != 0) ? MODE_DATA_FIRST : MODE_TX_REQ;
                duty_event();
              end
              MODE_LISTEN: begin
                mode = MODE_SLEEP;
                duty_event();
              end
              MODE_TX_DATA: mode = MODE_DATA_FIRST;
              default: ;
            endcase
          end else begin
            countdown = countdown - 32'd1;
          end
        end
      end
      REQ_START: begin
        if (mode == MODE_INIT) begin
          if (duty_en) begin
            mode = MODE_LISTEN;
            res.radio = RADIO_LISTEN;
            arm_timer(ev.offset);
          end else begin
            res.radio = RADIO_SLEEP;
          end
        end
      end
      REQ_RX_DONE: begin
        res.fwd = 1'b1;
        if (duty_en) begin
          armed = 1'b0;
          mode = MODE_SLEEP;
          duty_event();
        end
      end
      REQ_TX_PEND: begin
        if (mode != MODE_INIT) begin
          busy = 1'b0;
          armed = 1'b0;
          mode = MODE_LISTEN;
          duty_event();
        end
      end
      REQ_TX_DONE, REQ_TX_FAIL: begin
        if (mode != MODE_INIT) begin
          busy = 1'b0;
          if (mode == MODE_TX_REQ) begin
            armed = 1'b0;
            mode = MODE_SLEEP;
            duty_event();
          end else if (mode == MODE_TX_DATA && fill == 0) begin
            duty_event();
          end else if (fill != 0) begin
            // release the queue head and move on
            armed = 1'b0;
            res.relv = 1'b1;
            res.relh = fifo[0];
            fill--;
            for (i = 0; i < QDEPTH - 1; i++) fifo[i] = fifo[i + 1];
            if (fill != 0) begin
              send_head();
            end else if (mode == MODE_DATA_FIRST) begin
              mode = MODE_TX_REQ;
              res.tkind = TX_DATA_REQ;
            end else begin
              mode = MODE_SLEEP;
              res.radio = RADIO_SLEEP;
              arm_timer(sleep_len);
            end
          end
        end
      end
      REQ_SEND: begin
        if (mode == MODE_INIT) begin
          res.tkind = TX_DATA;
          res.thandle = ev.handle;
        end else if ((armed && countdown < guard_len) || fill != 0 || busy) begin
          if (fill < QDEPTH) begin
            fifo[fill] = ev.handle;
            fill++;
          end else begin
            res.drop = 1'b1;
          end
        end else begin
          mode = MODE_TX_DATA;
          busy = 1'b1;
          res.tkind = TX_DATA;
          res.thandle = ev.handle;
        end
      end
      default: ;
    endcase
    res.state = mode;
    res.count = 3'(fill);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      $display("mismatch %s: got %0h expected %0h at %0t", name, got, exp_val, $realtime);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_ev = event_queue.pop_front();
        in_valid <= 1'b1;
        req_type <= drive_ev.kind;
        packet_handle <= drive_ev.handle;
        start_offset <= drive_ev.offset;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          check_field("results waiting", 0, 1);
        end else begin
          want = expected_results.pop_front();
          check_field("radio_mode", 32'(radio_mode), 32'(want.radio));
          check_field("transmit_kind", 32'(transmit_kind), 32'(want.tkind));
          check_field("tx_handle", 32'(tx_handle), 32'(want.thandle));
          check_field("release_valid", 32'(release_valid), 32'(want.relv));
          check_field("released_handle", 32'(released_handle), 32'(want.relh));
          check_field("forward_rx", 32'(forward_rx), 32'(want.fwd));
          check_field("dropped", 32'(dropped), 32'(want.drop));
          check_field("mac_state", 32'(mac_state), 32'(want.state));
          check_field("queued_count", 32'(queued_count), 32'(want.count));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_event({req_type, packet_handle, start_offset}));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic offer(input logic [2:0] kind, input logic [7:0] handle,
                       input logic [31:0] offset);
    event_queue.push_back({kind, handle, offset});
  endtask

  task automatic drain();
    while (event_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DUTY_ENABLE: duty_en = val[0];
      CFG_SLEEP_TICKS: sleep_len = val;
      CFG_LISTEN_TICKS: listen_len = val;
      default: guard_len = val;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic duty, input logic [31:0] sleep_v,
                           input logic [31:0] listen_v, input logic [31:0] guard_v,
                           input int sidle, input int rstall, input bit hold, input int n);
    int r;
    int k;
    logic [2:0] kind;
    drain();
    write_reg(CFG_DUTY_ENABLE, {31'd0, duty});
    write_reg(CFG_SLEEP_TICKS, sleep_v);
    write_reg(CFG_LISTEN_TICKS, listen_v);
    write_reg(CFG_GUARD_TICKS, guard_v);
    @(posedge clk);
    send_idle_pct <= sidle;
    recv_stall_pct <= rstall;
    if (hold) hold_req <= ~hold_req;
    @(negedge clk);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) kind = REQ_TICK;
      else if (r < 61) kind = REQ_SEND;
      else if (r < 71) kind = REQ_TX_DONE;
      else if (r < 77) kind = REQ_TX_FAIL;
      else if (r < 83) kind = REQ_TX_PEND;
      else if (r < 89) kind = REQ_RX_DONE;
      else if (r < 95) kind = REQ_START;
      else kind = REQ_UNUSED;
      offer(kind, 8'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // init mode, reset settings
    offer(REQ_SEND, 8'h00, 32'd0);
    offer(REQ_SEND, 8'hff, 32'd0);
    offer(REQ_TX_DONE, 8'h00, 32'd0);
    offer(REQ_TX_FAIL, 8'h00, 32'd0);
    offer(REQ_TX_PEND, 8'h00, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_UNUSED, 8'hff, 32'hffff_ffff);

    // duty cycling off while in init
    run_phase(1'b0, RESET_SLEEP_TICKS, RESET_LISTEN_TICKS, RESET_GUARD_TICKS, 0, 0, 1'b0, 0);
    offer(REQ_START, 8'h00, 32'd0);
    offer(REQ_RX_DONE, 8'h00, 32'd0);

    // start, fill the queue, drain it on wake-up
    run_phase(1'b1, 32'd3, 32'd2, 32'd1, 0, 0, 1'b0, 0);
    offer(REQ_START, 8'h00, 32'd2);
    offer(REQ_SEND, 8'h11, 32'd0);
    offer(REQ_SEND, 8'h22, 32'd0);
    offer(REQ_SEND, 8'h33, 32'd0);
    offer(REQ_SEND, 8'h44, 32'd0);
    offer(REQ_SEND, 8'h55, 32'd0);
    offer(REQ_SEND, 8'h66, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_TX_DONE, 8'h00, 32'd0);
    offer(REQ_TX_FAIL, 8'h00, 32'd0);
    offer(REQ_TX_DONE, 8'h00, 32'd0);
    offer(REQ_TX_DONE, 8'h00, 32'd0);
    offer(REQ_TX_DONE, 8'h00, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_TICK, 8'h00, 32'd0);
    offer(REQ_TX_PEND, 8'h00, 32'd0);

    run_phase(1'b1, 32'd4, 32'd3, 32'd2, 0, 0, 1'b0, 150);
    run_phase(1'b1, 32'd1, 32'd1, 32'd0, 82, 0, 1'b0, 150);
    run_phase(1'b1, 32'd6, 32'd2, 32'hffff_ffff, 0, 82, 1'b0, 150);
    run_phase(1'b0, 32'd5, 32'd3, 32'd3, 23, 23, 1'b0, 150);
    run_phase(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'd5, 23, 23, 1'b0, 150);
    run_phase(1'b1, 32'd3, 32'd2, 32'd4, 0, 0, 1'b1, 150);
    run_phase(1'b1, 32'd8, 32'd4, 32'd6, 23, 23, 1'b0, 150);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
